>>> hw/rtl/reset_control_register_bank_macros.svh
// Assertion macros shared by the reset-control register bank.
`ifndef RESET_CONTROL_REGISTER_BANK_MACROS_SVH
`define RESET_CONTROL_REGISTER_BANK_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RCRB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define RCRB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hw/rtl/rcrb_pkg.sv
// Package with register descriptors and write rules of the reset-control bank.
package rcrb_pkg;

    typedef logic [31:0] word_t;

    // Per-register write rule: writable mask, request, done and persistent masks.
    typedef struct packed {
        logic  modelled;
        logic  we;
        word_t rst;
        word_t wmask;
        word_t rmask;
        word_t dmask;
        word_t pmask;
    } reg_desc_t;

    // Descriptor of one word index; unmodelled words store writes verbatim.
    function automatic reg_desc_t reg_desc(input logic [5:0] w);
        reg_desc_t d;
        d = '{modelled: 1'b1, we: 1'b0, rst: 32'h0, wmask: 32'hffffffff,
              rmask: 32'h0, dmask: 32'h0, pmask: 32'h0};
        case (w) inside
            6'd0:  d.rst = 32'h00fff880;
            6'd1:  begin d.we = 1'b1; d.wmask = 32'h0000701f;
                         d.rmask = 32'h11; d.dmask = 32'h1000; end
            6'd2:  d.rst = 32'h00066660;
            6'd3:  begin d.we = 1'b1; d.rst = 32'h1; d.wmask = 32'h00003011;
                         d.rmask = 32'h11; d.dmask = 32'h1000; d.pmask = 32'h1; end
            6'd4:  d.rst = 32'h00000880;
            6'd6:  d.rst = 32'h00000880;
            6'd8:  d.rst = 32'h00080800;
            6'd9:  begin d.rst = 32'h000ff0ff; d.wmask = 32'h000ff0ff; end
            6'd10: begin d.rst = 32'h007e7fff; d.wmask = 32'h007e7fff; end
            6'd11: begin d.wmask = 32'h33; d.rmask = 32'h3; d.dmask = 32'h30; end
            6'd12: d.rst = 32'h00080800;
            6'd13, 6'd17: begin d.wmask = 32'h70000007; d.rmask = 32'h7;
                         d.dmask = 32'h70000000; end
            6'd14: d.rst = 32'h0008d288;
            6'd15: begin d.wmask = 32'hf0000003; d.rmask = 32'h3;
                         d.dmask = 32'hf0000000; end
            6'd16: d.rst = 32'h00080c00;
            6'd18: d.rst = 32'h00080800;
            6'd20: d.rst = 32'h00040400;
            6'd21: begin d.wmask = 32'h30000003; d.rmask = 32'h3;
                         d.dmask = 32'h30000000; end
            6'd22: d.rst = 32'h00040400;
            6'd24: d.rst = 32'h00020200;
            6'd25: begin d.rst = 32'h2; d.wmask = 32'hd000000f; d.rmask = 32'hd;
                         d.dmask = 32'hd0000000; end
            6'd26: d.rst = 32'h00020200;
            6'd28: d.rst = 32'h00000304;
            6'd30: d.rst = 32'h00030202;
            6'd31: d.rst = 32'h00020202;
            6'd32: begin d.rst = 32'h0000039f; d.wmask = 32'h300003ff;
                         d.rmask = 32'h60; d.dmask = 32'h30000000; end
            6'd33: d.rst = 32'h00020200;
            6'd35: d.rst = 32'h00040404;
            6'd37: d.rst = 32'h00040404;
            6'd40: d.rst = 32'h00000880;
            6'd42: ;
            6'd5, 6'd7, 6'd19, 6'd23, 6'd27, 6'd29, 6'd34, 6'd36, 6'd39,
            6'd41: begin d.wmask = 32'h80000001; d.rmask = 32'h1;
                         d.dmask = 32'h80000000; end
            default: d.modelled = 1'b0;
        endcase
        return d;
    endfunction

    // Done bits latched by each request bit of a register.
    function automatic word_t done_of(input logic [5:0] w, input word_t fire);
        word_t s;
        s = '0;
        case (w) inside
            6'd1, 6'd3: s[12] = fire[0];
            6'd11: begin s[4] = fire[0]; s[5] = fire[1]; end
            6'd13, 6'd17: begin s[28] = fire[0]; s[29] = fire[1]; s[30] = fire[2]; end
            6'd15: begin s[28] = fire[0]; s[29] = fire[1];
                         s[30] = fire[0]; s[31] = fire[1]; end
            6'd21: begin s[28] = fire[0]; s[29] = fire[1]; end
            6'd25: begin s[28] = fire[0]; s[30] = fire[2]; s[31] = fire[3]; end
            6'd32: begin s[29] = fire[6]; s[28] = fire[5]; end
            6'd5, 6'd7, 6'd19, 6'd23, 6'd27, 6'd29, 6'd34, 6'd36, 6'd39,
            6'd41: s[31] = fire[0];
            default: ;
        endcase
        return s;
    endfunction

    // New word value after a write to a word.
    function automatic word_t apply_write(input logic [5:0] w, input word_t old,
                                          input word_t v);
        reg_desc_t d;
        word_t     gate;
        word_t     sw;
        word_t     nv;
        word_t     fire;
        d    = reg_desc(w);
        gate = d.we ? {16'h0, v[31:16]} : 32'hffffffff;
        sw   = ((~d.rmask & ~d.dmask) | d.pmask) & gate & d.wmask;
        nv   = (old & ~sw) | (v & sw);
        nv   = nv & ~(v & d.dmask & gate);
        fire = v & d.rmask & (d.we ? {16'h0, v[31:16]} : 32'hffffffff);
        nv   = nv | done_of(w, fire);
        nv   = nv & ~(fire & ~d.pmask);
        return d.modelled ? nv : v;
    endfunction

endpackage

>>> hw/rtl/rcrb_ram.sv
// Generic single-port RAM with registered read.
module rcrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Registered read; a write in the same cycle reads back the old word.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> hw/rtl/reset_control_register_bank.sv
// Reset-control register bank: bus accesses against a RAM-held register file.
//
// Usage: each input transaction on s_axis is one access. s_axis_tuser holds
// kind, s_axis_tdata holds byte_offset (bits 15:0) and write_data (bits
// 47:16). One result transaction leaves on m_axis per access: tdata holds
// read_data (bits 31:0), bad_access (32), wdt0_reset (33) and wdt1_reset (34).
// A good access reads the register word from the RAM at the accepting edge;
// at the next edge a write stores the modified word and the result is loaded
// into the output register. A bad access loads its result at the accepting
// edge itself. The input is only ready while the output register is empty,
// so a new access is accepted only after the previous result has left.
// After reset the block sweeps the RAM, writing each word's reset value,
// one word per cycle, with s_axis_tready low throughout the sweep.
// While the receiver stalls, the result stays in the output register and
// the next access is held off until it is taken.
`include "reset_control_register_bank_macros.svh"
module reset_control_register_bank #(
    parameter int NUM_WORDS = 1024,
    parameter int WDT0_BIT  = 0,
    parameter int WDT1_BIT  = 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind
    input  logic        s_axis_tuser,
    // byte_offset, write_data from bit 0 up
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data, bad_access, wdt0_reset, wdt1_reset from bit 0 up
    output logic [39:0] m_axis_tdata
);
    localparam int AW = $clog2(NUM_WORDS);
    localparam logic [1:0] ST_CLEAR = 2'd0, ST_IDLE = 2'd1, ST_MOD = 2'd2;
    localparam logic [5:0] PERI0_WORD = 6'd9;

    logic [1:0]  state_reg, state_next;
    logic [AW:0] clr_reg;
    logic        kind_reg;
    logic [AW-1:0] addr_reg;
    logic [31:0] wd_reg;
    logic        m_valid_reg;
    logic [39:0] m_data_reg;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0] ram_wdata, ram_rdata;
    logic        acc;
    logic        bad;
    logic [13:0] word_idx;
    logic [5:0]  small_idx;
    logic [5:0]  cur_small;
    logic [39:0] mod_result;

    assign s_axis_tready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign acc       = s_axis_tvalid && s_axis_tready;
    assign word_idx  = s_axis_tdata[15:2];
    assign bad       = (s_axis_tdata[1:0] != 2'b00) || (word_idx >= 14'(NUM_WORDS));
    assign small_idx = (clr_reg < (AW+1)'(64)) ? clr_reg[5:0] : 6'd63;
    assign cur_small = ({1'b0, addr_reg} < (AW+1)'(64)) ? addr_reg[5:0] : 6'd63;

    // RAM port selection: clearing sweep, write-back, or access read.
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = word_idx[AW-1:0];
        ram_wdata = rcrb_pkg::apply_write(cur_small, ram_rdata, wd_reg);
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg[AW-1:0];
            ram_wdata = rcrb_pkg::reg_desc(small_idx).rst;
            if (clr_reg >= (AW+1)'(64)) ram_wdata = '0;
        end else if (state_reg == ST_MOD) begin
            ram_we   = kind_reg;
            ram_addr = addr_reg;
        end
    end

    rcrb_ram #(.WIDTH(32), .DEPTH(NUM_WORDS)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == (AW+1)'(NUM_WORDS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (acc && !bad) state_next = ST_MOD;
            ST_MOD:   state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if ((state_reg == ST_MOD) || (acc && bad)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result of a good access: read data, or the watchdog pulses of a write to PERI0_WORD.
    always_comb begin
        mod_result = '0;
        if (!kind_reg) begin
            mod_result[31:0] = ram_rdata;
        end else if (addr_reg == AW'(PERI0_WORD)) begin
            mod_result[33] = wd_reg[WDT0_BIT];
            mod_result[34] = wd_reg[WDT1_BIT];
        end
    end

    // Access capture and result register.
    always_ff @(posedge aclk) begin
        if (acc) begin
            kind_reg <= s_axis_tuser;
            addr_reg <= word_idx[AW-1:0];
            wd_reg   <= s_axis_tdata[47:16];
        end
        if (acc && bad) begin
            m_data_reg <= {7'h0, 1'b1, 32'h0};
        end else if (state_reg == ST_MOD) begin
            m_data_reg <= mod_result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    `RCRB_ASSERT_IMP(a_no_accept_clear, aclk, aresetn, state_reg == ST_CLEAR,
        !s_axis_tready, "accept during clear")
    `RCRB_ASSERT_NEXT(a_mod_result, aclk, aresetn, state_reg == ST_MOD,
        m_axis_tvalid, "no result after access")
    `RCRB_ASSERT_IMP(a_bad_zero, aclk, aresetn, m_axis_tvalid && m_axis_tdata[32],
        m_axis_tdata[31:0] == 32'h0 && m_axis_tdata[34:33] == 2'b00,
        "bad access with data")
endmodule
